// ----- src/ray_segment_nearest_hit_assert.svh -----
// Assertion macros shared by the RTL.
`ifndef RAY_SEGMENT_NEAREST_HIT_ASSERT_SVH
`define RAY_SEGMENT_NEAREST_HIT_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RSNH_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, sampled on clock, off during reset.
`define RSNH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- src/rsnh_pkg.sv -----
package rsnh_pkg;

   localparam int SEGMENTS = 16;
   localparam int SEG_AW   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int SEG_CW   = $clog2(SEGMENTS + 1);
   localparam int COORD_W  = 32;
   localparam int ENTRY_W  = 4 * COORD_W;

   localparam int REQ_DATA_W = 296;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int CNT_REG_W  = 5;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam int MA_W   = 38;
   localparam int MB_W   = 34;
   localparam int MP_W   = MA_W + MB_W;
   localparam int ACC_W  = 76;
   localparam int NUM_W  = 100;
   localparam int DEN_W  = 63;
   localparam int QUOT_W = 32;
   localparam int DIV_CW = $clog2(QUOT_W);

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_CAST = 2'd1;

   localparam logic [0:0] REG_SEGMENT_COUNT = 1'b0;

   localparam logic [15:0] QUARTER_TURN = 16'h4000;
   localparam logic [31:0] ONE_Q30 = 32'd1073741824;
   localparam logic [31:0] SC1 = 32'd1686629713;
   localparam logic [31:0] SC3 = 32'd693598668;
   localparam logic [31:0] SC5 = 32'd85569306;
   localparam logic [31:0] SC7 = 32'd5026996;
   localparam logic [31:0] SC9 = 32'd172272;

   localparam logic [2:0] SIN_SQUARE = 3'd0;
   localparam logic [2:0] SIN_FIRST  = 3'd1;
   localparam logic [2:0] SIN_LAST   = 3'd5;

   typedef enum logic [1:0] {MAC_HOLD, MAC_LOAD, MAC_ADD, MAC_SUB} mac_op_type;

   typedef struct packed {
      mac_op_type             op;
      logic signed [MA_W-1:0] a;
      logic signed [MB_W-1:0] b;
   } mac_cmd_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SIN, ST_ORG, ST_RD, ST_PREP, ST_DEN, ST_NU, ST_NT, ST_CHK, ST_DIV, ST_DONE
   } state_type;

endpackage

// ----- src/ray_segment_nearest_hit.sv -----
// Range-sensor raycast against a table of up to 16 wall segments. A segment load or a cast
// for a disabled sensor goes from transfer through the done state to the result register. A
// cast runs longer for more segments in use (shorter for parallel or missed segments): one
// two-stage 38x34 multiplier does all sine, origin and cross-product work, and a restoring
// divider yields one quotient bit a cycle. A new item is taken while the previous result
// still waits on the rsp side.
`include "ray_segment_nearest_hit_assert.svh"

module ray_segment_nearest_hit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // seg_index, seg_start_x, seg_start_y, seg_end_x, seg_end_y, pose_x, pose_y,
   // pose_angle, sensor_right, sensor_forward, sensor_yaw, zero fill
   input  logic [rsnh_pkg::REQ_DATA_W-1:0]      req_tdata,
   // mode
   input  logic [rsnh_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // range
   output logic [rsnh_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // hit
   output logic                                 rsp_tuser,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rsnh_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [rsnh_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [rsnh_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                 csr_pready
);
   import rsnh_pkg::*;

   localparam int OX_W = 36;
   localparam int SG_W = 33;
   localparam int W_W  = 37;

   state_type                state_ff, state_in;
   logic [1:0]               cnt_ff, cnt_in;
   logic [2:0]               step_ff, step_in;
   logic [1:0]               ang_ff, ang_in;
   logic                     org_ff, org_in;
   logic [SEG_CW-1:0]        seg_ff, seg_in, used_ff, used_in, seg_next;
   logic [CNT_REG_W-1:0]     count_ff, count_in;

   logic signed [31:0]       px_ff, px_in, py_ff, py_in, rt_ff, rt_in, fw_ff, fw_in;
   logic [15:0]              th_ff, th_in, ray_ff, ray_in;
   logic [30:0]              x2_ff, x2_in;
   logic [31:0]              p_ff, p_in;
   logic signed [31:0]       c_ff, c_in, s_ff, s_in;
   logic signed [29:0]       dx_ff, dx_in, dy_ff, dy_in;
   logic signed [OX_W-1:0]   ox_ff, ox_in, oy_ff, oy_in;
   logic signed [SG_W-1:0]   sgx_ff, sgx_in, sgy_ff, sgy_in;
   logic signed [W_W-1:0]    wx_ff, wx_in, wy_ff, wy_in;
   logic signed [63:0]       den_ff, den_in, nu_ff, nu_in;
   logic                     found_ff, found_in;
   logic [31:0]              best_ff, best_in;
   logic                     rsp_valid_ff, rsp_valid_in, hit_ff, hit_in;
   logic [31:0]              range_ff, range_in;

   logic                     req_fire, csr_write, ram_we;
   logic [ENTRY_W-1:0]       ram_rdata;
   logic [3:0]               req_seg_index;
   logic [1:0]               req_mode;
   logic [15:0]              ang_val;
   logic [14:0]              xq;
   logic [30:0]              x_big;
   logic [31:0]              coef, v_raw, v_clamp;
   logic signed [31:0]       sv;
   logic signed [31:0]       e_sx, e_sy, e_ex, e_ey;
   logic signed [ACC_W-1:0]  acc, tn;
   logic signed [63:0]       dn, nn;
   logic                     neg;

   mac_cmd_type              mac_cmd;
   div_cmd_type              div_cmd;
   div_stat_type             div_stat;

   assign req_mode      = req_tuser;
   assign req_seg_index = req_tdata[3:0];
   assign req_tready    = (state_ff == ST_IDLE);
   assign req_fire      = req_tvalid && req_tready;
   assign ram_we        = req_fire && (req_mode == MODE_LOAD) &&
                          (int'(req_seg_index) < SEGMENTS);

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == REG_SEGMENT_COUNT);
   assign csr_prdata = (csr_paddr[2] == REG_SEGMENT_COUNT) ?
                       CSR_DW'(count_ff) : '0;
   assign count_in   = csr_write ? csr_pwdata[CNT_REG_W-1:0] : count_ff;

   rsnh_ram #(.WIDTH(ENTRY_W), .DEPTH(SEGMENTS)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (SEG_AW'(req_seg_index)),
      .wdata (req_tdata[131:4]),
      .raddr (seg_ff[SEG_AW-1:0]),
      .rdata (ram_rdata)
   );

   rsnh_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .acc   (acc)
   );

   rsnh_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   assign e_sx = $signed(ram_rdata[31:0]);
   assign e_sy = $signed(ram_rdata[63:32]);
   assign e_ex = $signed(ram_rdata[95:64]);
   assign e_ey = $signed(ram_rdata[127:96]);

   assign ang_val = (ang_ff[1] ? ray_ff : th_ff) + (ang_ff[0] ? 16'h0000 : QUARTER_TURN);
   assign xq      = ang_val[14] ? (15'd16384 - {1'b0, ang_val[13:0]}) : {1'b0, ang_val[13:0]};
   assign x_big   = {xq, 16'b0};
   assign v_raw   = acc[61:30];
   assign v_clamp = (v_raw > ONE_Q30) ? ONE_Q30 : v_raw;
   assign sv      = ang_val[15] ? (32'sd0 - $signed(v_clamp)) : $signed(v_clamp);

   always_comb begin
      unique case (step_ff)
         3'd1:    coef = SC7;
         3'd2:    coef = SC5;
         3'd3:    coef = SC3;
         default: coef = SC1;
      endcase
   end

   assign neg      = den_ff[63];
   assign dn       = neg ? (64'sd0 - den_ff) : den_ff;
   assign nn       = neg ? (64'sd0 - nu_ff) : nu_ff;
   assign tn       = neg ? ($signed(ACC_W'(0)) - acc) : acc;
   assign seg_next = seg_ff + SEG_CW'(1);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = '0;
      step_in      = step_ff;
      ang_in       = ang_ff;
      org_in       = org_ff;
      seg_in       = seg_ff;
      used_in      = used_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rt_in        = rt_ff;
      fw_in        = fw_ff;
      th_in        = th_ff;
      ray_in       = ray_ff;
      x2_in        = x2_ff;
      p_in         = p_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      sgx_in       = sgx_ff;
      sgy_in       = sgy_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      den_in       = den_ff;
      nu_in        = nu_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      hit_in       = hit_ff;
      range_in     = range_ff;
      mac_cmd.op   = MAC_HOLD;
      mac_cmd.a    = '0;
      mac_cmd.b    = '0;
      div_cmd.start = 1'b0;
      div_cmd.num   = NUM_W'(tn) << 28;
      div_cmd.den   = dn[DEN_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               found_in = 1'b0;
               best_in  = '1;
               px_in    = $signed(req_tdata[163:132]);
               py_in    = $signed(req_tdata[195:164]);
               th_in    = req_tdata[211:196];
               rt_in    = $signed(req_tdata[243:212]);
               fw_in    = $signed(req_tdata[275:244]);
               ray_in   = req_tdata[211:196] + req_tdata[291:276];
               used_in  = (int'(count_ff) > SEGMENTS) ? SEG_CW'(SEGMENTS) : SEG_CW'(count_ff);
               step_in  = SIN_SQUARE;
               ang_in   = '0;
               org_in   = 1'b0;
               state_in = (req_mode == MODE_CAST) ? ST_SIN : ST_DONE;
            end
         end
         ST_SIN: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd0) begin
               mac_cmd.op = MAC_LOAD;
               priority if (step_ff == SIN_SQUARE) begin
                  mac_cmd.a = MA_W'({1'b0, x_big});
                  mac_cmd.b = MB_W'({1'b0, x_big});
               end else if (step_ff == SIN_LAST) begin
                  mac_cmd.a = MA_W'({1'b0, x_big});
                  mac_cmd.b = MB_W'(p_ff);
               end else begin
                  mac_cmd.a = MA_W'(x2_ff);
                  mac_cmd.b = (step_ff == SIN_FIRST) ? MB_W'(SC9) : MB_W'(p_ff);
               end
            end
            if (cnt_ff == 2'd3) begin
               priority if (step_ff == SIN_SQUARE) begin
                  x2_in   = acc[60:30];
                  step_in = step_ff + 3'd1;
               end else if (step_ff == SIN_LAST) begin
                  unique case (ang_ff)
                     2'd0:    c_in  = sv;
                     2'd1:    s_in  = sv;
                     2'd2:    dx_in = sv[31:2];
                     default: dy_in = sv[31:2];
                  endcase
                  step_in = SIN_SQUARE;
                  ang_in  = ang_ff + 2'd1;
                  if (ang_ff == 2'd3) begin
                     state_in = ST_ORG;
                  end
               end else begin
                  p_in    = coef - acc[61:30];
                  step_in = step_ff + 3'd1;
               end
            end
         end
         ST_ORG: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd0) begin
               mac_cmd.op = MAC_LOAD;
               mac_cmd.a  = MA_W'(fw_ff);
               mac_cmd.b  = org_ff ? MB_W'(s_ff) : MB_W'(c_ff);
            end else if (cnt_ff == 2'd1) begin
               mac_cmd.op = org_ff ? MAC_SUB : MAC_ADD;
               mac_cmd.a  = MA_W'(rt_ff);
               mac_cmd.b  = org_ff ? MB_W'(c_ff) : MB_W'(s_ff);
            end
            if (cnt_ff == 2'd3) begin
               if (org_ff) begin
                  oy_in  = OX_W'(py_ff) + OX_W'(acc >>> 30);
                  seg_in = '0;
                  state_in = (used_ff == '0) ? ST_DONE : ST_RD;
               end else begin
                  ox_in  = OX_W'(px_ff) + OX_W'(acc >>> 30);
                  org_in = 1'b1;
               end
            end
         end
         ST_RD: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            sgx_in   = SG_W'(e_ex) - SG_W'(e_sx);
            sgy_in   = SG_W'(e_ey) - SG_W'(e_sy);
            wx_in    = W_W'(e_sx) - W_W'(ox_ff);
            wy_in    = W_W'(e_sy) - W_W'(oy_ff);
            state_in = ST_DEN;
         end
         ST_DEN: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd0) begin
               mac_cmd.op = MAC_LOAD;
               mac_cmd.a  = MA_W'(sgy_ff);
               mac_cmd.b  = MB_W'(dx_ff);
            end else if (cnt_ff == 2'd1) begin
               mac_cmd.op = MAC_SUB;
               mac_cmd.a  = MA_W'(sgx_ff);
               mac_cmd.b  = MB_W'(dy_ff);
            end
            if (cnt_ff == 2'd3) begin
               den_in = acc[63:0];
               if (acc[63:0] == 64'd0) begin
                  seg_in   = seg_next;
                  state_in = (seg_next == used_ff) ? ST_DONE : ST_RD;
               end else begin
                  state_in = ST_NU;
               end
            end
         end
         ST_NU: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd0) begin
               mac_cmd.op = MAC_LOAD;
               mac_cmd.a  = MA_W'(wx_ff);
               mac_cmd.b  = MB_W'(dy_ff);
            end else if (cnt_ff == 2'd1) begin
               mac_cmd.op = MAC_SUB;
               mac_cmd.a  = MA_W'(wy_ff);
               mac_cmd.b  = MB_W'(dx_ff);
            end
            if (cnt_ff == 2'd3) begin
               nu_in    = acc[63:0];
               state_in = ST_NT;
            end
         end
         ST_NT: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd0) begin
               mac_cmd.op = MAC_LOAD;
               mac_cmd.a  = MA_W'(wx_ff);
               mac_cmd.b  = MB_W'(sgy_ff);
            end else if (cnt_ff == 2'd1) begin
               mac_cmd.op = MAC_SUB;
               mac_cmd.a  = MA_W'(wy_ff);
               mac_cmd.b  = MB_W'(sgx_ff);
            end
            if (cnt_ff == 2'd3) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (tn[ACC_W-1] || nn[63] || (nn > dn)) begin
               seg_in   = seg_next;
               state_in = (seg_next == used_ff) ? ST_DONE : ST_RD;
            end else begin
               div_cmd.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               if (!found_ff || (div_stat.quot < best_ff)) begin
                  best_in = div_stat.quot;
               end
               found_in = 1'b1;
               seg_in   = seg_next;
               state_in = (seg_next == used_ff) ? ST_DONE : ST_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               hit_in       = found_ff;
               range_in     = found_ff ? best_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         step_ff      <= SIN_SQUARE;
         ang_ff       <= '0;
         org_ff       <= 1'b0;
         seg_ff       <= '0;
         used_ff      <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         ang_ff       <= ang_in;
         org_ff       <= org_in;
         seg_ff       <= seg_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff    <= px_in;
      py_ff    <= py_in;
      rt_ff    <= rt_in;
      fw_ff    <= fw_in;
      th_ff    <= th_in;
      ray_ff   <= ray_in;
      x2_ff    <= x2_in;
      p_ff     <= p_in;
      c_ff     <= c_in;
      s_ff     <= s_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      sgx_ff   <= sgx_in;
      sgy_ff   <= sgy_in;
      wx_ff    <= wx_in;
      wy_ff    <= wy_in;
      den_ff   <= den_in;
      nu_ff    <= nu_in;
      best_ff  <= best_in;
      hit_ff   <= hit_in;
      range_ff <= range_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = range_ff;
   assign rsp_tuser  = hit_ff;

   `RSNH_ASSERT_NEXT(a_busy_after_transfer, req_tvalid && req_tready, state_ff != ST_IDLE)
   `RSNH_ASSERT_IMP(a_no_hit_zero_range, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   `RSNH_ASSERT_IMP(a_div_running, state_ff == ST_DIV, div_stat.busy || div_stat.done)
   `RSNH_ASSERT_IMP(a_seg_in_use, state_ff == ST_PREP, seg_ff < used_ff)

endmodule

// ----- src/rsnh_ram.sv -----
module rsnh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/rsnh_mac.sv -----
module rsnh_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  rsnh_pkg::mac_cmd_type             cmd,
   output logic signed [rsnh_pkg::ACC_W-1:0] acc
);
   import rsnh_pkg::*;

   logic signed [MP_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   mac_op_type              op_ff;

   assign prod_in = cmd.a * cmd.b;

   always_comb begin
      unique case (op_ff)
         MAC_LOAD: acc_in = ACC_W'(prod_ff);
         MAC_ADD:  acc_in = acc_ff + ACC_W'(prod_ff);
         MAC_SUB:  acc_in = acc_ff - ACC_W'(prod_ff);
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= MAC_HOLD;
      end else begin
         op_ff <= cmd.op;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ----- src/rsnh_div.sv -----
module rsnh_div (
   input  logic                   clock,
   input  logic                   reset,
   input  rsnh_pkg::div_cmd_type  cmd,
   output rsnh_pkg::div_stat_type stat
);
   import rsnh_pkg::*;

   localparam int DSH_W = DEN_W + QUOT_W - 1;

   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [DSH_W-1:0]  dsh_ff, dsh_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic              ge;

   assign ge = rem_ff >= NUM_W'(dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         if (cmd.num >= (NUM_W'(cmd.den) << QUOT_W)) begin
            q_in    = '1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = cmd.num;
            dsh_in  = DSH_W'(cmd.den) << (QUOT_W - 1);
            q_in    = '0;
            cnt_in  = DIV_CW'(QUOT_W - 1);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - NUM_W'(dsh_ff);
         end
         q_in   = {q_ff[QUOT_W-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - DIV_CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.quot = q_ff;

endmodule
